>>> src/gray_histogram_256_defines.svh
// ----------------------------------------------------------------------------
// gray_histogram_256_defines.svh - assertion macros
// Implication checks on clk with asynchronous reset arst_n.
// ----------------------------------------------------------------------------
`ifndef GRAY_HISTOGRAM_256_DEFINES_SVH
`define GRAY_HISTOGRAM_256_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define GH_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gray_histogram_256: same-cycle check failed");
// next-cycle implication
`define GH_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gray_histogram_256: next-cycle check failed");
`else
`define GH_ASSERT_IMP(lbl, ante, cons)
`define GH_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> src/ghist_pkg.sv
// ----------------------------------------------------------------------------
// ghist_pkg - shared constants and types
// Bin geometry, count saturation, kind codes and the controller command.
// ----------------------------------------------------------------------------
package ghist_pkg;

	localparam int BINS       = 256;
	localparam int MAX_PIXELS = 1048576;
	localparam int ADDR_W     = $clog2(BINS);
	localparam int KIND_W     = 2;
	localparam int PIX_W      = 8;
	localparam int COUNT_W    = 21;

	localparam int COUNT_MAX = (1 << COUNT_W) - 1;
	localparam int COUNT_CAP = (MAX_PIXELS < COUNT_MAX) ? MAX_PIXELS : COUNT_MAX;

	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic clr;     // drop all valid bits
		logic rd;      // latch address, issue RAM read
		logic sel_bin; // address from bin_index, else pixel_value
		logic inc;     // write back incremented count
		logic ld_out;  // load result register
	} ghist_cmd_t;

endpackage

>>> src/ghist_ram.sv
// ----------------------------------------------------------------------------
// ghist_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ghist_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/ghist_dp.sv
// ----------------------------------------------------------------------------
// ghist_dp - histogram datapath
// Bin RAM, per-bin valid bits, saturating increment and result register.
// ----------------------------------------------------------------------------
module ghist_dp
	import ghist_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  ghist_cmd_t         cmd,
	input  logic [PIX_W-1:0]   pixel_value,
	input  logic [PIX_W-1:0]   bin_index,
	output logic [COUNT_W-1:0] bin_count
);

	logic [BINS-1:0]    vld_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               range_q;
	logic [COUNT_W-1:0] count_q;

	logic [PIX_W-1:0]   sel_val;
	logic [ADDR_W-1:0]  rd_addr;
	logic               in_range;
	logic [COUNT_W-1:0] ram_rdata;
	logic [COUNT_W-1:0] cur_count;
	logic               wr_en;
	logic [COUNT_W-1:0] wr_data;

	assign sel_val  = cmd.sel_bin ? bin_index : pixel_value;
	assign rd_addr  = ADDR_W'(sel_val);
	assign in_range = (32'(sel_val) < 32'(BINS));

	// a bin never written since the last clear reads as zero
	assign cur_count = (range_q && vld_q[addr_q]) ? ram_rdata : '0;
	assign wr_en     = cmd.inc && range_q && (cur_count < COUNT_W'(COUNT_CAP));
	assign wr_data   = cur_count + COUNT_W'(1);

	ghist_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (BINS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_q),
		.wdata (wr_data),
		.re    (cmd.rd),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.clr) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[addr_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			addr_q  <= rd_addr;
			range_q <= in_range;
		end
		if (cmd.ld_out) begin
			count_q <= cur_count;
		end
	end

	assign bin_count = count_q;

endmodule

>>> src/ghist_ctrl.sv
// ----------------------------------------------------------------------------
// ghist_ctrl - histogram controller
// Sequences clear, read-modify-write and read-back; owns the result valid.
// ----------------------------------------------------------------------------
`include "gray_histogram_256_defines.svh"

module ghist_ctrl
	import ghist_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [KIND_W-1:0] kind,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ghist_cmd_t        cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_INC  = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       in_acc;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (kind)
						KIND_CLEAR: begin
							cmd.clr = 1'b1;
						end
						KIND_PIXEL: begin
							cmd.rd    = 1'b1;
							state_nxt = ST_INC;
						end
						KIND_READ: begin
							cmd.rd      = 1'b1;
							cmd.sel_bin = 1'b1;
							state_nxt   = ST_RD;
						end
						default: begin
						end
					endcase
				end
			end
			ST_INC: begin
				cmd.inc   = 1'b1;
				state_nxt = ST_IDLE;
			end
			ST_RD: begin
				if (slot_free) begin
					cmd.ld_out = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`GH_ASSERT_NXT(a_pixel_goes_inc, in_acc && (kind == KIND_PIXEL), state_q == ST_INC)
	`GH_ASSERT_NXT(a_read_goes_rd, in_acc && (kind == KIND_READ), state_q == ST_RD)
	`GH_ASSERT_IMP(a_no_overwrite, cmd.ld_out, !out_valid_q || out_ready)
	`GH_ASSERT_NXT(a_rd_gives_result, (state_q == ST_RD) && slot_free, out_valid_q)

endmodule

>>> src/gray_histogram_256.sv
// ----------------------------------------------------------------------------
// gray_histogram_256 - 256-bin gray-level histogram
// Saturating per-bin pixel counts with clear and read-back transactions.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    kind, pixel_value, bin_index
//   out      output     out_valid / out_ready  bin_count
//
// Clear drops the valid bits at once. Pixel: RAM read, then saturating
//   increment and write back on the one write port.
// Read: RAM read, then result load after any wait for the result register to drain.
// Reset clears the per-bin valid bits; no RAM sweep, block ready right away.
// A stalled out channel stalls the input only once a read waits for the result
//   register; clear and pixel transactions keep flowing while a result waits.
//
module gray_histogram_256
	import ghist_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [KIND_W-1:0]  kind,
	input  logic [PIX_W-1:0]   pixel_value,
	input  logic [PIX_W-1:0]   bin_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COUNT_W-1:0] bin_count
);

	ghist_cmd_t cmd;

	// sequencer: one transaction in flight, result valid lives here
	ghist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// bin storage, valid bits, increment and result register
	ghist_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.pixel_value (pixel_value),
		.bin_index   (bin_index),
		.bin_count   (bin_count)
	);

endmodule

>>> verif/gray_histogram_256_test.sv
// ----------------------------------------------------------------------------
// gray_histogram_256_test - self-checking bench for the gray-level histogram
// Drives clear, pixel, read and unused-kind transactions through the valid/ready
// input, keeps a shadow set of saturating bin counters, and checks every
// read-back count in order. Both channels idle at random, the receiver holds
// off once for a long stretch, and one bin is hit many times in a row.
// ----------------------------------------------------------------------------
module gray_histogram_256_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ghist_pkg::*;

	// kind 3 is not decoded by the block
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 5;
	localparam int RAND_ITEMS   = 740;
	localparam int TXQ_DEPTH    = 32;   // refill threshold of the pending queue
	localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
	localparam int DRAIN_CYCLES = 16;   // margin for a late pixel update
	localparam int WDOG_LIMIT   = 4000; // > hold-off + longest gaps on both sides
	localparam int MAX_PRINTS   = 40;
	localparam int HOT_HITS     = 20;

	localparam logic [PIX_W-1:0] HOT_BIN = 8'h3C;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [PIX_W-1:0]  pixel_value;
		logic [PIX_W-1:0]  bin_index;
	} hist_tx_t;

	// DUT ports; the driven ones are known from time zero
	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [KIND_W-1:0]  kind        = KIND_CLEAR;
	logic [PIX_W-1:0]   pixel_value = '0;
	logic [PIX_W-1:0]   bin_index   = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [COUNT_W-1:0] bin_count;

	// transactions waiting to be offered
	hist_tx_t tx_q[$];

	// shadow histogram and the read-back counts still owed by the block
	logic [COUNT_W-1:0] model_bins [BINS];
	logic [COUNT_W-1:0] owed_counts[$];

	// idling controls, set per phase by the stimulus
	bit tx_idle_en = 1'b0;
	bit rx_idle_en = 1'b0;
	int hold_reqs  = 0;
	int hold_done  = 0;

	// bookkeeping
	int err_cnt       = 0;
	int n_clear       = 0;
	int n_pixel       = 0;
	int n_read        = 0;
	int n_unused      = 0;
	int n_sat_hits    = 0;
	int n_checked     = 0;
	int n_in_blocked  = 0;
	int tx_gap        = 0;
	int rx_stall      = 0;
	int hold_left     = 0;
	int idle_cycles   = 0;

	gray_histogram_256 u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.pixel_value(pixel_value),
		.bin_index  (bin_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.bin_count  (bin_count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// mostly back-to-back, sometimes a short gap, now and then a long gap
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		err_cnt++;
		if (err_cnt <= MAX_PRINTS)
			$display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Shadow histogram: apply one accepted transaction, owe a count on a read.
	function automatic void histogram_step(input logic [KIND_W-1:0] k,
		input logic [PIX_W-1:0] pv, input logic [PIX_W-1:0] bi);
		logic [COUNT_W-1:0] val;
		case (k)
			KIND_CLEAR: begin
				foreach (model_bins[i])
					model_bins[i] = '0;
				n_clear++;
			end
			KIND_PIXEL: begin
				// a gray level past the last bin is dropped
				if (int'(pv) < BINS) begin
					if (int'(model_bins[pv]) < COUNT_CAP)
						model_bins[pv] = model_bins[pv] + 1'b1;
					else
						n_sat_hits++;
				end
				n_pixel++;
			end
			KIND_READ: begin
				// a bin past the last one reads as zero
				val = (int'(bi) < BINS) ? model_bins[bi] : '0;
				owed_counts.push_back(val);
				n_read++;
			end
			default: begin
				n_unused++;
			end
		endcase
	endfunction

	// Pending queue is kept short so long bursts do not pile up in memory.
	task automatic queue_tx(input logic [KIND_W-1:0] k, input logic [PIX_W-1:0] pv,
		input logic [PIX_W-1:0] bi);
		hist_tx_t t;
		while (tx_q.size() >= TXQ_DEPTH)
			@(posedge clk);
		t.kind        = k;
		t.pixel_value = pv;
		t.bin_index   = bi;
		tx_q.push_back(t);
	endtask

	// ------------------------------------------------------------------------
	// Input driver: predicts on every accepted transaction, then offers the
	// next one once the slot is free and any gap has run out. Valid and
	// payload only change when nothing is on offer or it was just taken.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : tx_driver
		hist_tx_t nxt;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			kind        <= KIND_CLEAR;
			pixel_value <= '0;
			bin_index   <= '0;
			tx_gap      <= 0;
			foreach (model_bins[i])
				model_bins[i] = '0;
		end else begin
			if (in_valid && in_ready)
				histogram_step(kind, pixel_value, bin_index);
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap   <= tx_gap - 1;
					in_valid <= 1'b0;
				end else if (tx_q.size() > 0) begin
					nxt = tx_q.pop_front();
					kind        <= nxt.kind;
					pixel_value <= nxt.pixel_value;
					bin_index   <= nxt.bin_index;
					in_valid    <= 1'b1;
					tx_gap      <= tx_idle_en ? pick_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Output monitor: checks each accepted count against the oldest one owed,
	// and drives out_ready with random stalls. A pending hold request makes
	// it drop ready for HOLD_CYCLES as soon as a result shows up, so reads
	// back up inside the block and in_ready has to fall.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : rx_monitor
		logic [COUNT_W-1:0] want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_stall  <= 0;
			hold_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_counts.size() == 0) begin
					report_mismatch("bin_count with no read pending", int'(bin_count), 0);
				end else begin
					want = owed_counts.pop_front();
					if (bin_count !== want)
						report_mismatch("bin_count", int'(bin_count), int'(want));
					n_checked++;
				end
			end
			if (hold_done != hold_reqs && out_valid) begin
				hold_done <= hold_done + 1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall  <= rx_stall - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				rx_stall  <= rx_idle_en ? pick_gap() : 0;
			end
		end
	end

	// Watchdog: ends the run if neither channel moves for too long.
	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && in_valid && !in_ready)
			n_in_blocked <= n_in_blocked + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("[%0t] timeout: no transaction for %0d cycles", $time, WDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		logic [PIX_W-1:0]  palette [4];
		logic [KIND_W-1:0] k;
		int                n_rand;
		int                frame_len;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed: reset state, field extremes, every kind, ignored
		// fields, unused kind, back-to-back updates of one bin, read right
		// after a write, clear
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		queue_tx(KIND_READ,  8'h00, 8'h00);
		queue_tx(KIND_READ,  8'hFF, 8'hFF);
		queue_tx(KIND_PIXEL, 8'h00, 8'hFF);
		queue_tx(KIND_PIXEL, 8'hFF, 8'h00);
		queue_tx(KIND_PIXEL, 8'hFF, 8'hFF);
		queue_tx(KIND_PIXEL, 8'h55, 8'hAA);
		queue_tx(KIND_PIXEL, 8'hAA, 8'h55);
		queue_tx(KIND_NONE,  8'h55, 8'h55);
		queue_tx(KIND_READ,  8'hFF, 8'h00);
		queue_tx(KIND_READ,  8'h00, 8'hFF);
		queue_tx(KIND_READ,  8'hAA, 8'h55);
		queue_tx(KIND_READ,  8'h55, 8'hAA);
		queue_tx(KIND_PIXEL, 8'hAA, 8'h00);
		queue_tx(KIND_PIXEL, 8'hAA, 8'h00);
		queue_tx(KIND_PIXEL, 8'hAA, 8'h00);
		queue_tx(KIND_READ,  8'h00, 8'hAA);
		queue_tx(KIND_NONE,  8'hAA, 8'hAA);
		queue_tx(KIND_READ,  8'h00, 8'hAA);
		queue_tx(KIND_CLEAR, 8'hFF, 8'hFF);
		queue_tx(KIND_READ,  8'h00, 8'h00);
		queue_tx(KIND_READ,  8'h00, 8'hFF);
		queue_tx(KIND_PIXEL, 8'h00, 8'h00);
		queue_tx(KIND_READ,  8'h00, 8'h00);
		queue_tx(KIND_CLEAR, 8'h00, 8'h00);

		// --- receiver hold-off: reads pile up behind a stalled output while
		// the sender keeps offering, so the input must stall too
		hold_reqs = hold_reqs + 1;
		repeat (8)
			queue_tx(KIND_PIXEL, PIX_W'($urandom_range(0, 3)), PIX_W'($urandom));
		repeat (48)
			queue_tx(KIND_READ, PIX_W'($urandom), PIX_W'($urandom_range(0, 5)));

		// --- one bin hit many times in a row, its neighbor left at zero
		queue_tx(KIND_CLEAR, 8'h00, 8'h00);
		repeat (HOT_HITS)
			queue_tx(KIND_PIXEL, HOT_BIN, PIX_W'($urandom));
		queue_tx(KIND_READ, 8'h00, HOT_BIN);
		repeat (3)
			queue_tx(KIND_PIXEL, HOT_BIN, 8'h00);
		queue_tx(KIND_READ,  8'h00, HOT_BIN);
		queue_tx(KIND_READ,  8'h00, HOT_BIN + 1'b1);
		queue_tx(KIND_PIXEL, HOT_BIN, 8'hFF);
		queue_tx(KIND_READ,  8'hFF, HOT_BIN);
		queue_tx(KIND_CLEAR, 8'h00, 8'h00);
		queue_tx(KIND_READ,  8'h00, HOT_BIN);

		// --- random: mostly frames (clear, pixels biased to a few hot bins,
		// reads mixed in, read-back at the end), some loose noise
		n_rand = 0;
		while (n_rand < RAND_ITEMS) begin
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) < 15) begin
				k = KIND_W'($urandom_range(0, 3));
				queue_tx(k, PIX_W'($urandom), PIX_W'($urandom));
				if (k != KIND_NONE)
					n_rand++;
			end else begin
				foreach (palette[i])
					palette[i] = PIX_W'($urandom);
				if ($urandom_range(0, 9) < 7) begin
					queue_tx(KIND_CLEAR, PIX_W'($urandom), PIX_W'($urandom));
					n_rand++;
				end
				frame_len = $urandom_range(4, 40);
				repeat (frame_len) begin
					if ($urandom_range(0, 4) == 0)
						queue_tx(KIND_READ, PIX_W'($urandom),
							$urandom_range(0, 1) ? palette[$urandom_range(0, 3)]
							                     : PIX_W'($urandom));
					else
						queue_tx(KIND_PIXEL,
							$urandom_range(0, 1) ? palette[$urandom_range(0, 3)]
							                     : PIX_W'($urandom),
							PIX_W'($urandom));
					n_rand++;
				end
				repeat ($urandom_range(2, 6)) begin
					queue_tx(KIND_READ, PIX_W'($urandom), palette[$urandom_range(0, 3)]);
					n_rand++;
				end
			end
		end

		// --- drain: everything offered, every owed count back, then a wait
		// for a late pixel update or a stray result
		while (!(tx_q.size() == 0 && !in_valid && owed_counts.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d clears, %0d pixels (%0d at the cap), %0d reads, %0d unused-kind",
			n_clear, n_pixel, n_sat_hits, n_read, n_unused);
		$display("Checked %0d counts; input back-pressure in %0d cycles; %0d mismatches",
			n_checked, n_in_blocked, err_cnt);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
